[rtl/mppt_pkg.sv]
package mppt_pkg;

  localparam int DUTY_BITS_DEF = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PANEL_POWER_MAX     = 3'd0,
    CFG_BATTERY_VOLTAGE_MAX = 3'd1,
    CFG_DUTY_MIN            = 3'd2,
    CFG_DUTY_MAX            = 3'd3,
    CFG_DUTY_INITIAL        = 3'd4,
    CFG_SWEEP_STEP          = 3'd5,
    CFG_PERTURB_STEP        = 3'd6,
    CFG_SWEEP_PASSES        = 3'd7
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [31:0] PANEL_POWER_MAX_RST     = 32'hFFFF_FFFF;
  localparam logic [15:0] BATTERY_VOLTAGE_MAX_RST = 16'hFFFF;
  localparam logic [7:0]  DUTY_MIN_RST            = 8'd0;
  localparam logic [7:0]  DUTY_MAX_RST            = 8'd255;
  localparam logic [7:0]  DUTY_INITIAL_RST        = 8'd128;
  localparam logic [7:0]  SWEEP_STEP_RST          = 8'd1;
  localparam logic [6:0]  PERTURB_STEP_RST        = 7'd1;
  localparam logic [3:0]  SWEEP_PASSES_RST        = 4'd1;

  // One measurement sample.
  typedef struct packed {
    logic [31:0] panel_power;
    logic [15:0] panel_voltage;
    logic [15:0] panel_current;
    logic [15:0] battery_voltage;
  } sample_t;

  // Configuration values whose widths do not follow the duty width.
  typedef struct packed {
    logic [31:0] panel_power_max;
    logic [15:0] battery_voltage_max;
    logic [7:0]  sweep_step;
    logic [6:0]  perturb_step;
    logic [3:0]  sweep_passes;
    logic        reload;
  } cfg_fix_t;

  // Status flags of one result item.
  typedef struct packed {
    logic sweeping;
    logic sweep_done;
    logic power_limited;
    logic voltage_limited;
  } flags_t;

endpackage

[rtl/mppt_if.sv]
interface mppt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] panel_power;
  logic [15:0] panel_voltage;
  logic [15:0] panel_current;
  logic [15:0] battery_voltage;

  modport source (output valid, output panel_power, output panel_voltage,
                  output panel_current, output battery_voltage, input ready);
  modport sink (input valid, input panel_power, input panel_voltage,
                input panel_current, input battery_voltage, output ready);
endinterface

interface mppt_out_if import mppt_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty;
  logic                 sweeping;
  logic                 sweep_done;
  logic                 power_limited;
  logic                 voltage_limited;
  logic [31:0]          best_power;
  logic [DUTY_BITS-1:0] best_duty;

  modport source (output valid, output duty, output sweeping, output sweep_done,
                  output power_limited, output voltage_limited, output best_power,
                  output best_duty, input ready);
  modport sink (input valid, input duty, input sweeping, input sweep_done,
                input power_limited, input voltage_limited, input best_power,
                input best_duty, output ready);
endinterface

[rtl/mppt_cfg.sv]
module mppt_cfg import mppt_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_fix_t                 cfg_o,
  output logic [DUTY_BITS-1:0]     duty_min,
  output logic [DUTY_BITS-1:0]     duty_max,
  output logic [DUTY_BITS-1:0]     duty_initial
);

  cfg_fix_t             cfg_r;
  logic [DUTY_BITS-1:0] duty_min_r, duty_max_r, duty_initial_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_power_max     <= PANEL_POWER_MAX_RST;
      cfg_r.battery_voltage_max <= BATTERY_VOLTAGE_MAX_RST;
      cfg_r.sweep_step          <= SWEEP_STEP_RST;
      cfg_r.perturb_step        <= PERTURB_STEP_RST;
      cfg_r.sweep_passes        <= SWEEP_PASSES_RST;
      cfg_r.reload              <= 1'b0;
      duty_min_r                <= DUTY_BITS'(DUTY_MIN_RST);
      duty_max_r                <= DUTY_BITS'(DUTY_MAX_RST);
      duty_initial_r            <= DUTY_BITS'(DUTY_INITIAL_RST);
    end else begin
      // Writes that touch reset-dependent state ask the core to reload it.
      cfg_r.reload <= cfg_we && (cfg_index == CFG_DUTY_INITIAL ||
                                 cfg_index == CFG_PERTURB_STEP ||
                                 cfg_index == CFG_SWEEP_PASSES);
      if (cfg_we) begin
        case (cfg_index)
          CFG_PANEL_POWER_MAX:     cfg_r.panel_power_max <= cfg_data[31:0];
          CFG_BATTERY_VOLTAGE_MAX: cfg_r.battery_voltage_max <= cfg_data[15:0];
          CFG_DUTY_MIN:            duty_min_r <= cfg_data[DUTY_BITS-1:0];
          CFG_DUTY_MAX:            duty_max_r <= cfg_data[DUTY_BITS-1:0];
          CFG_DUTY_INITIAL:        duty_initial_r <= cfg_data[DUTY_BITS-1:0];
          CFG_SWEEP_STEP:          cfg_r.sweep_step <= cfg_data[7:0];
          CFG_PERTURB_STEP:        cfg_r.perturb_step <= cfg_data[6:0];
          CFG_SWEEP_PASSES:        cfg_r.sweep_passes <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o        = cfg_r;
  assign duty_min     = duty_min_r;
  assign duty_max     = duty_max_r;
  assign duty_initial = duty_initial_r;

endmodule

[rtl/mppt_core.sv]
module mppt_core import mppt_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  sample_t              sample,
  input  cfg_fix_t             cfg,
  input  logic [DUTY_BITS-1:0] duty_min,
  input  logic [DUTY_BITS-1:0] duty_max,
  input  logic [DUTY_BITS-1:0] duty_initial,
  output logic [DUTY_BITS-1:0] duty,
  output flags_t               flags,
  output logic [31:0]          best_power,
  output logic [DUTY_BITS-1:0] best_duty
);

  // Sweep arithmetic holds a duty plus an 8-bit step without overflow.
  localparam int SW = ((DUTY_BITS > 8) ? DUTY_BITS : 8) + 1;
  // Tracking arithmetic holds a duty plus seven steps, signed.
  localparam int TW = ((DUTY_BITS > 10) ? DUTY_BITS : 10) + 2;

  logic [DUTY_BITS-1:0] duty_now_r, duty_now_nxt;
  logic signed [7:0]    signed_step_r, signed_step_nxt;
  logic [31:0]          prev_power_r;
  logic [15:0]          prev_bv_r;
  logic [31:0]          peak_power_r, peak_power_nxt;
  logic [DUTY_BITS-1:0] peak_duty_r, peak_duty_nxt;
  logic                 going_down_r, going_down_nxt;
  logic [3:0]           passes_left_r, passes_left_nxt;
  logic                 final_rise_r, final_rise_nxt;
  logic                 tracking_r, tracking_nxt;
  logic                 started_r;

  always_comb begin
    logic [SW-1:0]        step_w;
    logic [SW-1:0]        duty_w;
    logic [SW-1:0]        rise_w;
    logic [DUTY_BITS-1:0] target;
    logic signed [7:0]    step_t;
    logic signed [TW-1:0] s1, s2, s4, d_w, hi_w, lo_w;

    duty_now_nxt    = duty_now_r;
    signed_step_nxt = signed_step_r;
    peak_power_nxt  = peak_power_r;
    peak_duty_nxt   = peak_duty_r;
    going_down_nxt  = going_down_r;
    passes_left_nxt = passes_left_r;
    final_rise_nxt  = final_rise_r;
    tracking_nxt    = tracking_r;
    flags           = '0;
    flags.sweeping  = !tracking_r;

    step_w = SW'(cfg.sweep_step);
    duty_w = SW'(duty_now_r);
    rise_w = '0;
    target = '0;
    step_t = (sample.panel_power <= prev_power_r) ? -signed_step_r : signed_step_r;
    s1     = TW'(step_t);
    s2     = s1 <<< 1;
    s4     = s1 <<< 2;
    d_w    = $signed(TW'(duty_now_r)) + s1;
    hi_w   = $signed(TW'(duty_max));
    lo_w   = $signed(TW'(duty_min));

    if (!tracking_r) begin
      if (sample.panel_power > peak_power_r) begin
        peak_power_nxt = sample.panel_power;
        peak_duty_nxt  = duty_now_r;
      end
      if (!final_rise_r) begin
        if (going_down_r) begin
          if (duty_now_r > duty_min) begin
            if (duty_w >= SW'(duty_min) + step_w) begin
              duty_now_nxt = DUTY_BITS'(duty_w - step_w);
            end else begin
              duty_now_nxt = duty_min;
            end
          end else begin
            going_down_nxt = 1'b0;
            if (passes_left_r != 4'd0) begin
              passes_left_nxt = passes_left_r - 4'd1;
            end
          end
        end else begin
          if (step_w <= SW'(duty_max) && duty_w < SW'(duty_max) - step_w) begin
            duty_now_nxt = DUTY_BITS'(duty_w + step_w);
          end else begin
            going_down_nxt = 1'b1;
          end
        end
        if (passes_left_nxt == 4'd0) begin
          final_rise_nxt = 1'b1;
        end
      end
      // The rise can start on the same sample that ends the last pass.
      if (final_rise_nxt) begin
        target = (duty_initial > duty_max) ? duty_max : duty_initial;
        if (duty_now_nxt < target) begin
          rise_w       = SW'(duty_now_nxt) + step_w;
          duty_now_nxt = (rise_w > SW'(duty_max)) ? duty_max : DUTY_BITS'(rise_w);
        end else begin
          duty_now_nxt     = peak_duty_nxt;
          flags.sweep_done = 1'b1;
          tracking_nxt     = 1'b1;
        end
      end
    end else begin
      signed_step_nxt = step_t;
      if (sample.panel_power > cfg.panel_power_max) begin
        flags.power_limited = 1'b1;
        d_w = (sample.panel_power < prev_power_r) ? d_w + s2 : d_w - s2;
      end
      if (sample.battery_voltage > cfg.battery_voltage_max) begin
        flags.voltage_limited = 1'b1;
        d_w = (sample.battery_voltage < prev_bv_r) ? d_w + s4 : d_w - s4;
      end
      if (d_w > hi_w) d_w = hi_w;
      if (d_w < lo_w) d_w = lo_w;
      duty_now_nxt = DUTY_BITS'(d_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_now_r    <= DUTY_BITS'(DUTY_INITIAL_RST);
      signed_step_r <= $signed({1'b0, PERTURB_STEP_RST});
      prev_power_r  <= '0;
      prev_bv_r     <= '0;
      peak_power_r  <= '0;
      peak_duty_r   <= DUTY_BITS'(DUTY_INITIAL_RST);
      going_down_r  <= 1'b1;
      passes_left_r <= SWEEP_PASSES_RST;
      final_rise_r  <= (SWEEP_PASSES_RST == 4'd0);
      tracking_r    <= 1'b0;
      started_r     <= 1'b0;
    end else if (fire) begin
      duty_now_r    <= duty_now_nxt;
      signed_step_r <= signed_step_nxt;
      prev_power_r  <= sample.panel_power;
      prev_bv_r     <= sample.battery_voltage;
      peak_power_r  <= peak_power_nxt;
      peak_duty_r   <= peak_duty_nxt;
      going_down_r  <= going_down_nxt;
      passes_left_r <= passes_left_nxt;
      final_rise_r  <= final_rise_nxt;
      tracking_r    <= tracking_nxt;
      started_r     <= 1'b1;
    end else if (cfg.reload && !started_r) begin
      duty_now_r    <= duty_initial;
      peak_duty_r   <= duty_initial;
      signed_step_r <= $signed({1'b0, cfg.perturb_step});
      passes_left_r <= cfg.sweep_passes;
      final_rise_r  <= (cfg.sweep_passes == 4'd0);
    end
  end

  assign duty       = duty_now_nxt;
  assign best_power = peak_power_nxt;
  assign best_duty  = peak_duty_nxt;

endmodule

[rtl/mppt_duty_controller.sv]
// Path: an accepted sample item waits in the sample register, and its result
// item is registered in the result register once that register can take it.
// Throughput: one item per cycle while the sink takes each result; the sample register
// and the result register each hold one item; the state update is one pass between them.
// Reset: synchronous on rst_n low; configuration returns to its reset values,
// the tracker restarts its sweep from duty_initial and both stages empty.
module mppt_duty_controller import mppt_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mppt_in_if.sink                  in_ch,
  mppt_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Configuration registers. A write of duty_initial, perturb_step or
  // sweep_passes before the first sample also reloads the tracker state
  // that resets from those values, through a registered reload request.
  cfg_fix_t             cfg;
  logic [DUTY_BITS-1:0] duty_min, duty_max, duty_initial;

  mppt_cfg #(.DUTY_BITS(DUTY_BITS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_o        (cfg),
    .duty_min     (duty_min),
    .duty_max     (duty_max),
    .duty_initial (duty_initial)
  );

  // Sample register. It takes a new item whenever it is empty or its
  // current item moves on in the same cycle.
  sample_t sample_r;
  logic    sample_valid_r;
  logic    fire;

  // The core consumes the held sample when the result register can take
  // its result: either it is empty or the sink takes its item now.
  assign fire        = sample_valid_r && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !sample_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      sample_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r.panel_power     <= in_ch.panel_power;
      sample_r.panel_voltage   <= in_ch.panel_voltage;
      sample_r.panel_current   <= in_ch.panel_current;
      sample_r.battery_voltage <= in_ch.battery_voltage;
    end
  end

  // Sweep and perturb-and-observe state, updated once per consumed sample.
  logic [DUTY_BITS-1:0] duty_c, best_duty_c;
  logic [31:0]          best_power_c;
  flags_t               flags_c;

  mppt_core #(.DUTY_BITS(DUTY_BITS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .sample       (sample_r),
    .cfg          (cfg),
    .duty_min     (duty_min),
    .duty_max     (duty_max),
    .duty_initial (duty_initial),
    .duty         (duty_c),
    .flags        (flags_c),
    .best_power   (best_power_c),
    .best_duty    (best_duty_c)
  );

  // Result register. It holds an item until the sink takes it.
  logic                 out_valid_r;
  logic [DUTY_BITS-1:0] duty_r, best_duty_r;
  logic [31:0]          best_power_r;
  flags_t               flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      duty_r       <= duty_c;
      flags_r      <= flags_c;
      best_power_r <= best_power_c;
      best_duty_r  <= best_duty_c;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.duty            = duty_r;
  assign out_ch.sweeping        = flags_r.sweeping;
  assign out_ch.sweep_done      = flags_r.sweep_done;
  assign out_ch.power_limited   = flags_r.power_limited;
  assign out_ch.voltage_limited = flags_r.voltage_limited;
  assign out_ch.best_power      = best_power_r;
  assign out_ch.best_duty       = best_duty_r;

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mppt_pkg::*;

  localparam int DW             = DUTY_BITS_DEF;
  // The tracker corrects by twice its step on a power limit and four times on a
  // battery voltage limit.
  localparam int PWR_GAIN       = 2;
  localparam int VBAT_GAIN      = 4;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_PHASE     = 5;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;
  localparam int PLAN_ROWS      = 30;

  // One result item as the block presents it.
  typedef struct packed {
    logic [DW-1:0] duty;
    flags_t        flags;
    logic [31:0]   best_power;
    logic [DW-1:0] best_duty;
  } duty_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_FINISH_SWEEP
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    cfg_idx_e     reg_idx;
    logic [31:0]  reg_val;
    sample_t      smp;
    logic         typed;
    duty_result_t want;
  } stim_row_t;

  // Directed table. Register rows wait until the block is idle. The first
  // samples after the start-up writes have their results typed in: the sweep
  // goes down by the sweep step from the initial duty and latches the best
  // power. The finish-sweep row feeds random samples until the tracker has
  // taken over, and the rows after it work the limit corrections and the
  // saturation corners against the predictor.
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_WRITE,  CFG_DUTY_INITIAL, 32'd200, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_SWEEP_STEP,   32'd6,   '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_PERTURB_STEP, 32'd3,   '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_SWEEP_PASSES, 32'd2,   '0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd1000, 16'd0, 16'd0, 16'd0},
      1'b1, '{8'd194, 4'b1000, 32'd1000, 8'd200}},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b1, '{8'd188, 4'b1000, 32'd1000, 8'd200}},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd5000, 16'd1234, 16'd5678, 16'd42},
      1'b1, '{8'd182, 4'b1000, 32'd5000, 8'd188}},
    '{ROW_FINISH_SWEEP, CFG_PANEL_POWER_MAX, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'hFFFF_FFFF, 16'd100, 16'd200, 16'd300},
      1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd0, 16'd100, 16'd200, 16'd300}, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd0, 16'd100, 16'd200, 16'd300}, 1'b0, '0},
    '{ROW_WRITE,  CFG_PANEL_POWER_MAX,     32'd1000, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_BATTERY_VOLTAGE_MAX, 32'd500,  '0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd2000, 16'd0, 16'd0, 16'd100}, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd1500, 16'd0, 16'd0, 16'd600}, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd1500, 16'd0, 16'd0, 16'd550}, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{ROW_WRITE,  CFG_DUTY_MIN, 32'd250, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_DUTY_MAX, 32'd10,  '0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd3000, 16'd0, 16'd0, 16'd800}, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{ROW_WRITE,  CFG_DUTY_MIN,     32'd0,   '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_DUTY_MAX,     32'd255, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_PERTURB_STEP, 32'd127, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_SWEEP_STEP,   32'd255, '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_SWEEP_PASSES, 32'd15,  '0, 1'b0, '0},
    '{ROW_WRITE,  CFG_DUTY_INITIAL, 32'd0,   '0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd40000, 16'd300, 16'd400, 16'd200},
      1'b0, '0},
    '{ROW_SAMPLE, CFG_PANEL_POWER_MAX, '0, '{32'd39999, 16'd300, 16'd400, 16'd200},
      1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  mppt_in_if                   in_ch();
  mppt_out_if #(.DUTY_BITS(DW)) out_ch();

  mppt_duty_controller #(.DUTY_BITS(DW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies kept by the predictor.
  logic [31:0] lim_power;
  logic [15:0] lim_vbat;
  int          floor_duty, ceil_duty, start_duty, sweep_inc, po_step, pass_cfg;

  // Tracker state kept by the predictor.
  int          duty_q, top_duty, po_dir, passes_rem;
  logic [31:0] top_power, last_power;
  logic [15:0] last_vbat;
  bit          descending, rising, locked, touched;

  // Expected duty results in the order their samples were accepted.
  duty_result_t pending_duty[$];

  int errors = 0;
  bit snd_gaps = 1'b1;
  bit rcv_gaps = 1'b1;
  bit hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Registers that set the start of the sweep also reload the tracker while no
  // sample has been taken since reset.
  function automatic void load_start_state();
    duty_q     = start_duty;
    top_duty   = duty_q;
    po_dir     = po_step;
    passes_rem = pass_cfg;
    rising     = (pass_cfg == 0);
  endfunction

  // Advances the predicted tracker by one accepted sample and returns the
  // result item the block must produce for it.
  function automatic duty_result_t track_sample(input sample_t s);
    duty_result_t r;
    int           d;
    int           target;
    r = '0;
    r.flags.sweeping = !locked;
    touched = 1'b1;
    if (!locked) begin
      if (s.panel_power > top_power) begin
        top_power = s.panel_power;
        top_duty  = duty_q;
      end
      if (!rising) begin
        if (descending) begin
          if (duty_q > floor_duty) begin
            duty_q = (duty_q >= floor_duty + sweep_inc) ? duty_q - sweep_inc : floor_duty;
          end else begin
            descending = 1'b0;
            if (passes_rem > 0) passes_rem--;
          end
        end else if (ceil_duty >= sweep_inc && duty_q < ceil_duty - sweep_inc) begin
          duty_q += sweep_inc;
        end else begin
          descending = 1'b1;
        end
        if (passes_rem == 0) rising = 1'b1;
      end
      // The last leg climbs back to the initial duty, then jumps to the best one.
      if (rising) begin
        target = (start_duty > ceil_duty) ? ceil_duty : start_duty;
        if (duty_q < target) begin
          duty_q += sweep_inc;
          if (duty_q > ceil_duty) duty_q = ceil_duty;
        end else begin
          duty_q = top_duty;
          r.flags.sweep_done = 1'b1;
          locked = 1'b1;
        end
      end
    end else begin
      d = duty_q;
      if (s.panel_power <= last_power) po_dir = -po_dir;
      d += po_dir;
      if (s.panel_power > lim_power) begin
        r.flags.power_limited = 1'b1;
        if (s.panel_power < last_power) d += PWR_GAIN * po_dir;
        else d -= PWR_GAIN * po_dir;
      end
      if (s.battery_voltage > lim_vbat) begin
        r.flags.voltage_limited = 1'b1;
        if (s.battery_voltage < last_vbat) d += VBAT_GAIN * po_dir;
        else d -= VBAT_GAIN * po_dir;
      end
      // The ceiling is applied first, so the floor wins when the two cross.
      if (d > ceil_duty) d = ceil_duty;
      if (d < floor_duty) d = floor_duty;
      duty_q = d;
    end
    last_power = s.panel_power;
    last_vbat  = s.battery_voltage;
    r.duty       = duty_q[DW-1:0];
    r.best_power = top_power;
    r.best_duty  = top_duty[DW-1:0];
    return r;
  endfunction

  // Random measurements: mostly close to the limits or to the last sample so
  // that the trend comparisons and the limit checks go both ways, with equal
  // powers and wild values mixed in.
  function automatic sample_t next_sample();
    sample_t s;
    s.panel_voltage = 16'($urandom);
    s.panel_current = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       s.panel_power = $urandom;
      1:       s.panel_power = lim_power + $urandom_range(0, 64) - 32;
      2:       s.panel_power = last_power;
      default: s.panel_power = last_power + $urandom_range(0, 2000) - 1000;
    endcase
    case ($urandom_range(0, 3))
      0:       s.battery_voltage = 16'($urandom);
      1:       s.battery_voltage = 16'(lim_vbat + $urandom_range(0, 16) - 8);
      2:       s.battery_voltage = last_vbat;
      default: s.battery_voltage = 16'(last_vbat + $urandom_range(0, 200) - 100);
    endcase
    return s;
  endfunction

  // Offers one sample, possibly after an idle burst, and records its expected
  // result once the block takes it.
  task automatic send_item(input sample_t s, input logic typed, input duty_result_t want);
    duty_result_t predicted;
    @(negedge clk);
    if (snd_gaps && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.panel_power     <= s.panel_power;
    in_ch.panel_voltage   <= s.panel_voltage;
    in_ch.panel_current   <= s.panel_current;
    in_ch.battery_voltage <= s.battery_voltage;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = track_sample(s);
    pending_duty.push_back(typed ? want : predicted);
  endtask

  // Stops offering samples and waits until every expected result has arrived.
  // Each sample yields exactly one result, so the block is idle after that.
  task automatic drain_samples();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PANEL_POWER_MAX:     lim_power  = val;
      CFG_BATTERY_VOLTAGE_MAX: lim_vbat   = val[15:0];
      CFG_DUTY_MIN:            floor_duty = val[7:0];
      CFG_DUTY_MAX:            ceil_duty  = val[7:0];
      CFG_DUTY_INITIAL:        start_duty = val[7:0];
      CFG_SWEEP_STEP:          sweep_inc  = val[7:0];
      CFG_PERTURB_STEP:        po_step    = val[6:0];
      default:                 pass_cfg   = val[3:0];
    endcase
    if (!touched && (idx == CFG_DUTY_INITIAL || idx == CFG_PERTURB_STEP ||
                     idx == CFG_SWEEP_PASSES)) begin
      load_start_state();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The receiver stalls in random bursts. A hold request from the stimulus
  // keeps ready low for a long stretch so that both stages fill and the input
  // side backs up while samples are still being offered.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && rcv_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result item is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    duty_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_duty.size() == 0) begin
        report("result item arrived with no sample waiting for it");
      end else begin
        want = pending_duty.pop_front();
        check_field("duty", 32'(out_ch.duty), 32'(want.duty));
        check_field("sweeping", 32'(out_ch.sweeping), 32'(want.flags.sweeping));
        check_field("sweep_done", 32'(out_ch.sweep_done), 32'(want.flags.sweep_done));
        check_field("power_limited", 32'(out_ch.power_limited),
                    32'(want.flags.power_limited));
        check_field("voltage_limited", 32'(out_ch.voltage_limited),
                    32'(want.flags.voltage_limited));
        check_field("best_power", out_ch.best_power, want.best_power);
        check_field("best_duty", 32'(out_ch.best_duty), 32'(want.best_duty));
      end
    end
  end

  // The watchdog ends a run in which nothing moves on either channel for too
  // long; this also catches results that never arrive.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] pm, vm, lo, hi, init, sstep, pstep, npass;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.panel_power     = '0;
    in_ch.panel_voltage   = '0;
    in_ch.panel_current   = '0;
    in_ch.battery_voltage = '0;

    // The predictor starts from the register reset values.
    lim_power  = PANEL_POWER_MAX_RST;
    lim_vbat   = BATTERY_VOLTAGE_MAX_RST;
    floor_duty = DUTY_MIN_RST;
    ceil_duty  = DUTY_MAX_RST;
    start_duty = DUTY_INITIAL_RST;
    sweep_inc  = SWEEP_STEP_RST;
    po_step    = PERTURB_STEP_RST;
    pass_cfg   = SWEEP_PASSES_RST;
    top_power  = '0;
    last_power = '0;
    last_vbat  = '0;
    descending = 1'b1;
    locked     = 1'b0;
    touched    = 1'b0;
    load_start_state();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: start-up writes, the opening sweep samples, the rest of
    // the sweep, and then the tracking corners.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_WRITE: begin
          drain_samples();
          write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
        end
        ROW_SAMPLE: send_item(PLAN[i].smp, PLAN[i].typed, PLAN[i].want);
        default: begin
          while (!locked) send_item(next_sample(), 1'b0, '0);
        end
      endcase
    end

    // Random part. Each phase reprograms every register while the block is
    // idle. The first four phases pin the extremes: limits always acting,
    // limits never acting, and the duty window collapsed at either rail. The
    // sweep registers no longer matter once tracking runs, but they are still
    // written across their whole range.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_samples();
      pm    = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
      vm    = $urandom_range(0, 65535);
      lo    = $urandom_range(0, 120);
      hi    = $urandom_range(100, 255);
      init  = $urandom_range(0, 255);
      sstep = $urandom_range(1, 255);
      pstep = $urandom_range(1, 127);
      npass = $urandom_range(0, 15);
      case (p)
        0: begin
          pm = '0; vm = '0; lo = 0; hi = 255;
          init = 0; sstep = 1; pstep = 1; npass = 0;
        end
        1: begin
          pm = '1; vm = 32'hFFFF; lo = 0; hi = 255;
          init = 255; sstep = 255; pstep = 127; npass = 15;
        end
        2: begin
          lo = 255; hi = 255;
        end
        3: begin
          lo = 0; hi = 0;
        end
        default: ;
      endcase
      write_reg(CFG_PANEL_POWER_MAX, pm);
      write_reg(CFG_BATTERY_VOLTAGE_MAX, vm);
      write_reg(CFG_DUTY_MIN, lo);
      write_reg(CFG_DUTY_MAX, hi);
      write_reg(CFG_DUTY_INITIAL, init);
      write_reg(CFG_SWEEP_STEP, sstep);
      write_reg(CFG_PERTURB_STEP, pstep);
      write_reg(CFG_SWEEP_PASSES, npass);

      // Idle bursts come and go per phase; the final phase runs at full rate.
      snd_gaps = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rcv_gaps = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == HOLD_PHASE) hold_pending = 1'b1;
      repeat (PHASE_ITEMS) send_item(next_sample(), 1'b0, '0);
    end

    // Let the last results arrive, then give a stray extra result a chance to
    // show up before the verdict.
    drain_samples();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mppt_pkg.sv
rtl/mppt_if.sv
rtl/mppt_cfg.sv
rtl/mppt_core.sv
rtl/mppt_duty_controller.sv
dv/testbench.sv
